// ----- rtl/dht_pkg.sv -----
// ----------------------------------------------------------------------------
// dht_pkg
// types, codes and sizing constants shared by the hash table engine
// ----------------------------------------------------------------------------
package dht_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 1021;
    localparam int unsigned KEY_W  = 31;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned SIZE_W = 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_RSVD     = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]        operation;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data_value;
        logic [SIZE_W-1:0] data_size;
    } t_cmd;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] data_out;
        logic [SIZE_W-1:0] size_out;
    } t_rsp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

// ----- rtl/dht_modred.sv -----
// ----------------------------------------------------------------------------
// dht_modred
// remainder of a key by a constant modulus via reciprocal multiply
// ----------------------------------------------------------------------------
module dht_modred #(
    parameter int unsigned MODULUS = 1021,
    parameter int unsigned RW      = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [dht_pkg::KEY_W-1:0] i_key,
    output logic                   o_done,
    output logic [RW-1:0]          o_rem
);
    import dht_pkg::*;

    // quotient estimate from floor(2^QS / MODULUS) is low by at most one
    localparam int unsigned MW = $clog2(MODULUS);
    localparam int unsigned QS = KEY_W + MW;
    localparam int unsigned PW = 2 * KEY_W + 1;
    localparam logic [KEY_W:0] RECIP = (KEY_W+1)'((64'd1 << QS) / 64'(MODULUS));

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_q;
    logic [RW:0]      r_rem;
    logic [2:0]       r_v;
    logic [PW-1:0]    w_prod;
    logic [RW:0]      w_sub;

    // quotient estimate
    assign w_prod = PW'(r_key) * PW'(RECIP);

    // final correction, remainder is below twice the modulus
    assign w_sub  = r_rem - (RW+1)'(MODULUS);
    assign o_rem  = (r_rem >= (RW+1)'(MODULUS)) ? w_sub[RW-1:0] : r_rem[RW-1:0];
    assign o_done = r_v[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_start};
        end
        if (i_start) r_key <= i_key;
        r_q   <= KEY_W'(w_prod >> QS);
        r_rem <= (RW+1)'(r_key - r_q * KEY_W'(MODULUS));
    end

endmodule

// ----- rtl/dht_slot_ram.sv -----
// ----------------------------------------------------------------------------
// dht_slot_ram
// slot memory: flags, key and payload per slot, registered read
// ----------------------------------------------------------------------------
module dht_slot_ram #(
    parameter int unsigned DEPTH = 1021,
    parameter int unsigned AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [1+1+dht_pkg::KEY_W+dht_pkg::DATA_W+dht_pkg::SIZE_W-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [1+1+dht_pkg::KEY_W+dht_pkg::DATA_W+dht_pkg::SIZE_W-1:0] o_rdata
);
    import dht_pkg::*;

    localparam int unsigned W = 2 + KEY_W + DATA_W + SIZE_W;

    logic [W-1:0] r_mem [DEPTH];

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/double_hash_table_engine.sv -----
// ----------------------------------------------------------------------------
// double_hash_table_engine
// open addressing hash table with double hashing over one slot memory
// ----------------------------------------------------------------------------
// After reset the block clears the slot memory, one slot a cycle, with
// busy high. A command is taken when start is high and busy is low. Home
// slot and probe step come from two reciprocal multiply remainder units
// running side by side, then each probe of the slot memory is a read step
// followed by a check step, up to SLOT_COUNT probes; a no-op command skips
// the probes. An insert that fills a slot or a remove that hits adds a
// write step, and a done step presents the result. The result is on the
// ports for one cycle with o_valid high and cannot be held off; busy drops
// in the cycle after it.
module double_hash_table_engine #(
    parameter int unsigned SLOT_COUNT = dht_pkg::SLOT_COUNT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  dht_pkg::t_cmd   i_cmd,
    output logic            busy,
    output logic            o_valid,
    output dht_pkg::t_rsp   o_rsp
);
    import dht_pkg::*;

    localparam int unsigned AW = $clog2(SLOT_COUNT);
    localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
    localparam int unsigned W  = 2 + KEY_W + DATA_W + SIZE_W;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [AW-1:0] r_idx, n_idx, r_step;
    logic [CW-1:0] r_n, n_n;
    t_rsp   r_rsp, n_rsp;
    logic   w_accept;

    logic          w_hdone, w_sdone;
    logic [AW-1:0] w_home, w_srem;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [W-1:0]  w_wdata, w_rdata;
    logic          w_valid, w_removed;
    logic [KEY_W-1:0]  w_key;
    logic [DATA_W-1:0] w_data;
    logic [SIZE_W-1:0] w_size;
    logic [AW:0]   w_wrap;

    assign w_accept = start && !busy;
    assign {w_valid, w_removed, w_key, w_data, w_size} = w_rdata;

    // key remainders for home slot and probe step
    dht_modred #(.MODULUS(SLOT_COUNT), .RW(AW)) u_home (
        .i_clk, .i_rst_n, .i_start(w_accept), .i_key(i_cmd.key),
        .o_done(w_hdone), .o_rem(w_home)
    );
    dht_modred #(.MODULUS(SLOT_COUNT - 2), .RW(AW)) u_step (
        .i_clk, .i_rst_n, .i_start(w_accept), .i_key(i_cmd.key),
        .o_done(w_sdone), .o_rem(w_srem)
    );

    dht_slot_ram #(.DEPTH(SLOT_COUNT), .AW(AW)) u_ram (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_idx), .o_rdata(w_rdata)
    );

    // next probe slot with wrap
    assign w_wrap = ({1'b0, r_idx} >= {1'b0, r_step})
                  ? {1'b0, r_idx} - {1'b0, r_step}
                  : {1'b0, r_idx} + (AW+1)'(SLOT_COUNT) - {1'b0, r_step};

    // next state and probe bookkeeping
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_n     = r_n;
        n_rsp   = r_rsp;
        case (r_state)
            S_CLEAR: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == AW'(SLOT_COUNT - 1)) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end
            end
            S_IDLE: if (w_accept) n_state = S_MOD;
            S_MOD: begin
                n_rsp = '{status: ST_NOTFOUND, data_out: '0, size_out: '0};
                n_n   = '0;
                if (w_hdone && w_sdone) begin
                    n_idx   = w_home;
                    n_state = (r_cmd.operation == OP_NONE) ? S_DONE : S_READ;
                end
            end
            S_READ: n_state = S_CHECK;
            S_CHECK: begin
                n_n = r_n + 1'b1;
                if (r_cmd.operation == OP_INSERT) begin
                    if (!w_valid || w_removed) begin
                        n_rsp.status = ST_OK;
                        n_state = S_WRITE;
                    end else if (r_n == CW'(SLOT_COUNT - 1)) begin
                        n_rsp.status = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_idx = w_wrap[AW-1:0];
                        n_state = S_READ;
                    end
                end else begin
                    if (!w_valid) begin
                        n_state = S_DONE;
                    end else if (!w_removed && w_key == r_cmd.key) begin
                        n_rsp = '{status: ST_OK, data_out: w_data, size_out: w_size};
                        n_state = (r_cmd.operation == OP_REMOVE) ? S_WRITE : S_DONE;
                    end else if (r_n == CW'(SLOT_COUNT - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = w_wrap[AW-1:0];
                        n_state = S_READ;
                    end
                end
            end
            S_WRITE: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory write and handshake outputs
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = {1'b1, 1'b0, r_cmd.key, r_cmd.data_value, r_cmd.data_size};
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = '0;
            end
            S_WRITE: begin
                w_we = 1'b1;
                if (r_cmd.operation == OP_REMOVE)
                    w_wdata = {1'b1, 1'b1, r_cmd.key, r_rsp.data_out, r_rsp.size_out};
            end
            default: w_we = 1'b0;
        endcase
    end

    assign busy    = (r_state != S_IDLE) || !i_rst_n;
    assign o_valid = (r_state == S_DONE);
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        if (w_accept) r_cmd <= i_cmd;
        if (r_state == S_MOD && w_sdone) r_step <= w_srem + 1'b1;
        r_n   <= n_n;
        r_rsp <= n_rsp;
    end

endmodule
